[hdl/particle_sensor_frame_parser_top_assert.svh]
// ----------------------------------------------------------------------------
// Particle sensor frame parser assertion macros
// Shared implication checks, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define PSFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psfp: same-cycle check failed");

// next-cycle implication
`define PSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psfp: next-cycle check failed");

`endif

[hdl/psfp_pkg.sv]
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Frame constants, result status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psfp_pkg;

    localparam logic [7:0]  HDR_FIRST   = 8'h42;
    localparam logic [7:0]  HDR_SECOND  = 8'h4D;
    localparam logic [15:0] HDR_SUM     = 16'h008F;
    localparam logic [15:0] FRAME_LEN   = 16'd28;
    localparam logic [4:0]  SUM_BYTES   = 5'd28;
    localparam logic [4:0]  BODY_LAST   = 5'd29;
    localparam int          NUM_WORDS   = 13;
    localparam logic [3:0]  WORD_LEN    = 4'd0;
    localparam logic [3:0]  WORD_CSUM   = 4'd14;
    localparam logic [3:0]  LAST_INDEX  = 4'd12;

    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_BAD_LEN  = 2'd1;
    localparam logic [1:0]  ST_BAD_SUM  = 2'd2;

    typedef struct packed {
        logic       byte_acc;
        logic       sum_init;
        logic       sum_add;
        logic       hold_we;
        logic       word_we;
        logic [3:0] word_sel;
        logic       out_load;
        logic [1:0] out_status;
        logic [3:0] out_index;
        logic       out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr1;
        logic hdr2;
        logic len_ok;
        logic sum_ok;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hdl/psfp_ctrl.sv]
// ----------------------------------------------------------------------------
// Particle sensor frame parser controller
// Header hunt, body byte sequencing, frame check and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "particle_sensor_frame_parser_top_assert.svh"

module psfp_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  psfp_pkg::t_dp_status  i_status,
    output psfp_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_HUNT1 = 3'd0;
    localparam logic [2:0] S_HUNT2 = 3'd1;
    localparam logic [2:0] S_BODY  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [4:0] r_pos, n_pos;
    logic [3:0] r_idx, n_idx;
    logic       accept;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = (r_state == S_HUNT1) || (r_state == S_HUNT2) || (r_state == S_BODY);
        accept     = i_in_valid && o_in_ready;
        o_cmd.byte_acc = accept;
        o_cmd.word_sel = r_pos[4:1];
        unique case (r_state)
            S_HUNT1: begin
                if (accept && i_status.hdr1) begin
                    n_state = S_HUNT2;
                end
            end
            S_HUNT2: begin
                if (accept) begin
                    if (i_status.hdr2) begin
                        n_state        = S_BODY;
                        n_pos          = '0;
                        o_cmd.sum_init = 1'b1;
                    end else begin
                        n_state = S_HUNT1;
                    end
                end
            end
            S_BODY: begin
                if (accept) begin
                    o_cmd.sum_add = (r_pos < psfp_pkg::SUM_BYTES);
                    o_cmd.hold_we = !r_pos[0];
                    o_cmd.word_we = r_pos[0];
                    if (r_pos == psfp_pkg::BODY_LAST) begin
                        n_state = S_CHECK;
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.out_free) begin
                    priority if (!i_status.len_ok) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = psfp_pkg::ST_BAD_LEN;
                        o_cmd.out_last   = 1'b1;
                        n_state          = S_HUNT1;
                    end else if (!i_status.sum_ok) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = psfp_pkg::ST_BAD_SUM;
                        o_cmd.out_last   = 1'b1;
                        n_state          = S_HUNT1;
                    end else begin
                        n_state = S_EMIT;
                        n_idx   = '0;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = psfp_pkg::ST_OK;
                    o_cmd.out_index  = r_idx;
                    o_cmd.out_last   = (r_idx == psfp_pkg::LAST_INDEX);
                    if (r_idx == psfp_pkg::LAST_INDEX) begin
                        n_state = S_HUNT1;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT1;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_idx   <= n_idx;
        end
    end

    `PSFP_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n,
        (r_state == S_CHECK) || (r_state == S_EMIT), !o_in_ready)
    `PSFP_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_status.out_free)
    `PSFP_ASSERT_NOW(a_ok_last_index, i_clk, i_rst_n,
        o_cmd.out_load && (o_cmd.out_status == psfp_pkg::ST_OK),
        o_cmd.out_last == (o_cmd.out_index == psfp_pkg::LAST_INDEX))

endmodule

`default_nettype wire

[hdl/psfp_datapath.sv]
// ----------------------------------------------------------------------------
// Particle sensor frame parser datapath
// Checksum, word assembly, measurement word store and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "particle_sensor_frame_parser_top_assert.svh"

module psfp_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_rx_byte,
    input  psfp_pkg::t_dp_cmd     i_cmd,
    output psfp_pkg::t_dp_status  o_status,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic [3:0]            o_word_index,
    output logic [15:0]           o_word_value,
    output logic [1:0]            o_frame_status,
    output logic                  o_last
);

    logic [15:0] r_sum;
    logic [7:0]  r_hold;
    logic [15:0] r_len;
    logic [15:0] r_csum;
    logic [15:0] r_store [psfp_pkg::NUM_WORDS];
    logic        r_valid, n_valid;
    logic [3:0]  r_index;
    logic [15:0] r_value;
    logic [1:0]  r_fstat;
    logic        r_last;
    logic [15:0] word;
    logic        out_free;
    logic        store_we;
    logic        is_ok;

    assign word     = {r_hold, i_rx_byte};
    assign out_free = !r_valid || i_out_ready;
    assign store_we = i_cmd.byte_acc && i_cmd.word_we
                      && (i_cmd.word_sel != psfp_pkg::WORD_LEN)
                      && (i_cmd.word_sel != psfp_pkg::WORD_CSUM);
    assign is_ok    = (i_cmd.out_status == psfp_pkg::ST_OK);

    assign o_status.hdr1     = (i_rx_byte == psfp_pkg::HDR_FIRST);
    assign o_status.hdr2     = (i_rx_byte == psfp_pkg::HDR_SECOND);
    assign o_status.len_ok   = (r_len == psfp_pkg::FRAME_LEN);
    assign o_status.sum_ok   = (r_sum == r_csum);
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_sum <= psfp_pkg::HDR_SUM;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + {8'd0, i_rx_byte};
        end
        if (i_cmd.hold_we) begin
            r_hold <= i_rx_byte;
        end
        if (i_cmd.word_we && (i_cmd.word_sel == psfp_pkg::WORD_LEN)) begin
            r_len <= word;
        end
        if (i_cmd.word_we && (i_cmd.word_sel == psfp_pkg::WORD_CSUM)) begin
            r_csum <= word;
        end
        if (store_we) begin
            r_store[i_cmd.word_sel - 4'd1] <= word;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_index <= is_ok ? i_cmd.out_index : 4'd0;
            r_value <= is_ok ? r_store[i_cmd.out_index] : 16'd0;
            r_fstat <= i_cmd.out_status;
            r_last  <= i_cmd.out_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_word_index   = r_index;
    assign o_word_value   = r_value;
    assign o_frame_status = r_fstat;
    assign o_last         = r_last;

    `PSFP_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, i_cmd.out_load, r_valid)
    `PSFP_ASSERT_NOW(a_error_zero_last, i_clk, i_rst_n,
        r_valid && (r_fstat != psfp_pkg::ST_OK),
        (r_value == 16'd0) && r_last && (r_index == 4'd0))
    `PSFP_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, r_valid && !i_out_ready,
        r_valid && $stable(r_value) && $stable(r_index) && $stable(r_last))

endmodule

`default_nettype wire

[hdl/particle_sensor_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// Particle sensor frame parser top level
// Takes one byte per cycle while hunting the header and collecting the frame.
// Errors load in the check state, ok words in emit, via the output register;
// ok words go one per cycle while i_ready is high. Input stalls until the
// last result is loaded. Synchronous active-low reset returns to header hunt.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module particle_sensor_frame_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [3:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic [1:0]  o_frame_status,
    output logic        o_last
);

    psfp_pkg::t_dp_cmd    cmd;
    psfp_pkg::t_dp_status status;

    psfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    psfp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_word_index   (o_word_index),
        .o_word_value   (o_word_value),
        .o_frame_status (o_frame_status),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
